// ===== rtl/sfsb_pkg.sv =====
package sfsb_pkg;

    localparam int unsigned DirectUnits = 24;
    localparam int unsigned PosW        = 6;
    localparam int unsigned FrameW      = 56;

    localparam logic [7:0] SenseOffPattern = 8'h1C;

    localparam logic [0:0] FuncScan     = 1'b0;
    localparam logic [0:0] FuncReadback = 1'b1;

    localparam logic [0:0] CfgUseExpander = 1'b0;
    localparam logic [0:0] CfgTimeout     = 1'b1;

    // decoder base for expander sensor group j
    function automatic logic [7:0] decoder_base(input logic [1:0] j);
        logic [7:0] r;
        case (j)
            2'd0:    r = 8'h0C;
            2'd1:    r = 8'h18;
            2'd2:    r = 8'h14;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    // control from sequencer to frame assembler
    typedef struct packed {
        logic       clear;
        logic       emit;
        logic [1:0] cyc;
        logic       half;
        logic       last;
    } t_frame_ctl;

endpackage

// ===== rtl/sfsb_frame_asm.sv =====
module sfsb_frame_asm (
    input  logic                          i_clk,
    input  sfsb_pkg::t_frame_ctl          i_ctl,
    input  logic                          i_use_expander,
    input  logic [6:0]                    i_addr,
    input  logic                          i_mot_valid,
    input  logic [6:0]                    i_mot_idx,
    input  logic                          i_mot_on,
    output logic [sfsb_pkg::FrameW-1:0]   o_frame
);

    // accumulator for motor bits of the frame in progress, one unit a cycle
    logic [55:0] r_acc, n_acc;
    logic [55:0] sens, bit_m;
    logic [6:0]  k, km;
    logic [4:0]  jm;
    logic [2:0]  v;

    always_comb begin
        sens  = '0;
        bit_m = '0;
        k     = i_addr - 7'(sfsb_pkg::DirectUnits);
        km    = i_mot_idx - 7'(sfsb_pkg::DirectUnits);
        v     = k[2:0];
        if (i_addr < 7'(sfsb_pkg::DirectUnits)) begin
            // byte 4 bits 23..16, byte 2 bits 39..32, byte 1 bits 47..40
            case (i_addr[4:3])
                2'd0:    sens[23 - i_addr[2:0]] = 1'b1;
                2'd1:    sens[39 - i_addr[2:0]] = 1'b1;
                default: sens[47 - i_addr[2:0]] = 1'b1;
            endcase
            if (i_use_expander && i_ctl.cyc == 2'd3) sens[55:48] = sfsb_pkg::SenseOffPattern;
        end else if (i_use_expander) begin
            if ((k >= 7'd24) == i_ctl.half && i_ctl.cyc == 2'd3) begin
                sens[55:48] = sfsb_pkg::decoder_base(
                    (k >= 7'd24) ? 2'((k - 7'd24) >> 3) : 2'(k >> 3))
                    | {v[0], v[1], v[2], 5'b0};
            end
        end
        jm = (km >= 7'd24) ? 5'(km - 7'd24) : km[4:0];
        if (i_mot_valid && i_mot_on) begin
            if (i_mot_idx < 7'(sfsb_pkg::DirectUnits)) begin
                case (i_mot_idx[4:3])
                    2'd0:    bit_m[7 - i_mot_idx[2:0]]  = 1'b1;
                    2'd1:    bit_m[15 - i_mot_idx[2:0]] = 1'b1;
                    default: bit_m[31 - i_mot_idx[2:0]] = 1'b1;
                endcase
            end else if (i_use_expander && (km >= 7'd24) == i_ctl.half
                         && (2'd2 - 2'(jm >> 3)) == i_ctl.cyc) begin
                bit_m[48 + km[2:0]] = 1'b1;
            end
        end
        n_acc = i_ctl.clear ? '0 : (r_acc | bit_m);
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    assign o_frame = r_acc | sens;

endmodule

// ===== rtl/splitflap_scan_frame_builder.sv =====
// channel  | direction | ports
// command  | in        | i_start/o_busy, i_func .. i_sensor_byte
// result   | out       | o_valid, o_frame, o_mux_cycle, o_mux_half, o_mux_latch, o_last
// config   | in        | i_cfg_we, i_cfg_idx, i_cfg_data
// a scan item updates start/stop for the addressed unit, then walks all units once for
// timeout (one unit a cycle through a single subtract and compare), then walks
// them eight more times building one frame per walk; busy throughout a scan
// a readback or ignored scan keeps busy high for one cycle
// reset is synchronous, active low; stamp and position memories are cleared
// by a pass over all NUM_UNITS entries after reset, during which busy is high
// results cannot be stalled, one per strobe
module splitflap_scan_frame_builder #(
    parameter int unsigned NUM_UNITS = 72
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic        i_func,
    input  logic [6:0]  i_unit_addr,
    input  logic [5:0]  i_target_pos,
    input  logic        i_unit_present,
    input  logic [31:0] i_now_ms,
    input  logic [7:0]  i_sensor_byte,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    output logic        o_valid,
    output logic [55:0] o_frame,
    output logic [1:0]  o_mux_cycle,
    output logic        o_mux_half,
    output logic        o_mux_latch,
    output logic        o_last
);

    typedef enum logic [2:0] {
        S_CLR, S_IDLE, S_RD, S_UPD, S_TMO, S_FRM, S_OUT, S_REP
    } t_state;

    t_state r_state;
    logic        r_use_exp;
    logic [15:0] r_tmo;
    logic [NUM_UNITS-1:0] r_motor;
    logic [31:0] stamp_mem [NUM_UNITS];
    logic [5:0]  pos_mem [NUM_UNITS];
    logic [6:0]  r_idx;
    logic [2:0]  r_fnum;
    logic [6:0]  r_addr;
    logic [5:0]  r_tgt;
    logic [31:0] r_now;
    logic [31:0] r_stamp_rd;
    logic [5:0]  r_pos_rd;
    logic        r_rd_ok;
    logic [31:0] diff;
    sfsb_pkg::t_frame_ctl ctl;
    logic [55:0] frame_c;
    logic        mot_valid;

    assign diff = r_now - r_stamp_rd;
    assign mot_valid = (r_state == S_FRM) && r_rd_ok;

    always_comb begin
        ctl.clear = (r_state == S_TMO) || (r_state == S_OUT);
        ctl.emit  = (r_state == S_OUT);
        ctl.cyc   = r_fnum[1:0];
        ctl.half  = r_fnum[2];
        ctl.last  = 1'b0;
    end

    sfsb_frame_asm u_asm (
        .i_clk          (i_clk),
        .i_ctl          (ctl),
        .i_use_expander (r_use_exp),
        .i_addr         (r_addr),
        .i_mot_valid    (mot_valid),
        .i_mot_idx      (r_idx - 7'd1),
        .i_mot_on       (r_motor[r_idx - 7'd1]),
        .o_frame        (frame_c)
    );

    // memory port: read at r_idx, written per state
    always_ff @(posedge i_clk) begin
        r_stamp_rd <= stamp_mem[r_idx];
        r_pos_rd   <= pos_mem[r_idx];
        if (r_state == S_CLR) begin
            stamp_mem[r_idx] <= '0;
            pos_mem[r_idx]   <= '0;
        end else if (r_state == S_IDLE && i_start && i_func == sfsb_pkg::FuncReadback
                     && i_unit_addr < 7'(NUM_UNITS)) begin
            pos_mem[i_unit_addr] <= i_sensor_byte[5:0];
        end else if (r_state == S_UPD) begin
            if (r_tgt != r_pos_rd && !r_motor[r_addr]) stamp_mem[r_addr] <= r_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_use_exp <= 1'b1;
            r_tmo     <= 16'd5000;
            r_motor   <= '0;
            r_idx     <= '0;
            r_fnum    <= '0;
            r_rd_ok   <= 1'b0;
            o_valid   <= 1'b0;
            o_last    <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            o_last  <= 1'b0;
            if (i_cfg_we) begin
                if (i_cfg_idx == sfsb_pkg::CfgUseExpander) r_use_exp <= i_cfg_data[0];
                else r_tmo <= i_cfg_data;
            end
            case (r_state)
                S_CLR: begin
                    r_idx <= r_idx + 7'd1;
                    if (r_idx == 7'(NUM_UNITS - 1)) begin
                        r_idx   <= '0;
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_start) begin
                        r_addr <= i_unit_addr;
                        r_tgt  <= i_target_pos;
                        r_now  <= i_now_ms;
                        if (i_func == sfsb_pkg::FuncScan && i_unit_present
                            && i_unit_addr < 7'(NUM_UNITS)) begin
                            r_idx   <= i_unit_addr;
                            r_state <= S_RD;
                        end else begin
                            // no frames: keep the repeat marker clear
                            r_idx   <= '0;
                            r_state <= S_REP;
                        end
                    end
                end
                S_RD: r_state <= S_UPD;
                S_UPD: begin
                    if (r_tgt != r_pos_rd && !r_motor[r_addr]) r_motor[r_addr] <= 1'b1;
                    else if (r_motor[r_addr] && r_tgt == r_pos_rd) r_motor[r_addr] <= 1'b0;
                    r_idx   <= '0;
                    r_rd_ok <= 1'b0;
                    r_state <= S_TMO;
                end
                S_TMO: begin
                    // r_stamp_rd belongs to r_idx-1 once r_rd_ok
                    if (r_rd_ok && r_motor[r_idx - 7'd1] && diff >= {16'd0, r_tmo})
                        r_motor[r_idx - 7'd1] <= 1'b0;
                    r_rd_ok <= 1'b1;
                    r_idx   <= r_idx + 7'd1;
                    if (r_rd_ok && r_idx == 7'(NUM_UNITS)) begin
                        r_idx   <= '0;
                        r_fnum  <= '0;
                        r_rd_ok <= 1'b0;
                        r_state <= S_FRM;
                    end
                end
                S_FRM: begin
                    r_rd_ok <= 1'b1;
                    r_idx   <= r_idx + 7'd1;
                    if (r_rd_ok && r_idx == 7'(NUM_UNITS)) r_state <= S_OUT;
                end
                S_OUT: begin
                    o_valid     <= 1'b1;
                    o_frame     <= frame_c;
                    o_mux_cycle <= r_fnum[1:0];
                    o_mux_half  <= r_fnum[2];
                    o_mux_latch <= r_use_exp;
                    r_idx       <= '0;
                    r_rd_ok     <= 1'b0;
                    r_fnum      <= r_fnum + 3'd1;
                    r_state     <= (r_fnum == 3'd7) ? S_REP : S_FRM;
                    if (r_fnum == 3'd7) r_idx <= 7'd127;
                end
                S_REP: begin
                    // r_idx 127 marks a real scan needing the repeat frame
                    if (r_idx == 7'd127) begin
                        o_valid     <= 1'b1;
                        o_last      <= 1'b1;
                        o_mux_cycle <= 2'd3;
                        o_mux_half  <= 1'b1;
                        o_mux_latch <= 1'b0;
                    end
                    r_idx   <= '0;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // stamps are kept when a motor stops, but a stopped motor's stamp is never
    // used so holding the stale stamp is equivalent
    assign o_busy = (r_state != S_IDLE);

    a_last_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last |-> o_valid) else $error("last without strobe");
    a_last_mux: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last |-> (o_mux_cycle == 2'd3 && o_mux_half && !o_mux_latch))
        else $error("repeat frame fields");
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !o_valid || $past(r_state == S_REP))
        else $error("strobe while idle");

endmodule

// ===== tb/splitflap_scan_frame_builder_tb.sv =====
`timescale 1ns / 1ps

module splitflap_scan_frame_builder_tb;

    localparam int unsigned NUnits    = 72;
    localparam int unsigned CycleCap  = 1500000;
    localparam int unsigned DrainWait = 10 * NUnits + 40;

    // one expected frame as the block should present it
    typedef struct packed {
        logic [55:0] frame;
        logic [1:0]  cyc;
        logic        half;
        logic        latch;
        logic        last;
    } t_frame_exp;

    // shadow of the display state, and the queue of frames still owed
    class frame_board;
        bit          expander;
        bit [15:0]   timeout_ms;
        bit          running[NUnits];
        bit [31:0]   stamp[NUnits];
        bit [5:0]    position[NUnits];
        t_frame_exp  owed[$];
        int          errors;

        function void clear_state();
            expander   = 1'b1;
            timeout_ms = 16'd5000;
            foreach (running[m]) begin
                running[m]  = 1'b0;
                stamp[m]    = '0;
                position[m] = '0;
            end
        endfunction

        function void write_reg(logic idx, logic [15:0] val);
            if (idx == sfsb_pkg::CfgUseExpander) expander = val[0];
            else timeout_ms = val;
        endfunction

        function logic [55:0] make_frame(int unsigned addr, int unsigned half,
                                         int unsigned cyc);
            logic [7:0]  b[7];
            int unsigned k, j, v;
            logic [55:0] r;
            foreach (b[i]) b[i] = '0;
            if (addr < sfsb_pkg::DirectUnits) begin
                // direct sensor bytes are 4, 2, 1 for the groups of eight
                b[addr < 8 ? 4 : (addr < 16 ? 2 : 1)] = 8'h80 >> (addr % 8);
                if (expander && cyc == 3) b[0] = sfsb_pkg::SenseOffPattern;
            end else if (expander) begin
                k = addr - sfsb_pkg::DirectUnits;
                j = k % 24;
                v = j % 8;
                if (k / 24 == half && cyc == 3)
                    b[0] = (j < 8 ? 8'h0C : (j < 16 ? 8'h18 : 8'h14))
                         | {v[0], v[1], v[2], 5'b0};
            end
            for (int unsigned m = 0; m < NUnits; m++) begin
                if (!running[m]) continue;
                if (m < sfsb_pkg::DirectUnits) begin
                    b[m < 8 ? 6 : (m < 16 ? 5 : 3)] |= 8'h80 >> (m % 8);
                end else if (expander) begin
                    k = m - sfsb_pkg::DirectUnits;
                    j = k % 24;
                    if (k / 24 == half && 2 - j / 8 == cyc)
                        b[0] |= 8'h01 << (k % 8);
                end
            end
            r = '0;
            for (int i = 0; i < 7; i++) r = {r[47:0], b[i]};
            return r;
        endfunction

        // an accepted item updates the shadow and queues its frames
        function void note_item(logic func, logic [6:0] addr, logic [5:0] tgt,
                                logic present, logic [31:0] now,
                                logic [7:0] sens);
            t_frame_exp e;
            if (addr >= NUnits) return;
            if (func == sfsb_pkg::FuncReadback) begin
                position[addr] = sens[5:0];
                return;
            end
            if (!present) return;
            if (tgt != position[addr] && !running[addr]) begin
                running[addr] = 1'b1;
                stamp[addr]   = now;
            end else if (running[addr] && tgt == position[addr]) begin
                running[addr] = 1'b0;
                stamp[addr]   = '0;
            end
            for (int m = 0; m < NUnits; m++)
                if (running[m] && (now - stamp[m]) >= {16'd0, timeout_ms}) begin
                    running[m] = 1'b0;
                    stamp[m]   = '0;
                end
            for (int f = 0; f < 8; f++) begin
                e.frame = make_frame(addr, f / 4, f % 4);
                e.cyc   = 2'(f % 4);
                e.half  = 1'(f / 4);
                e.latch = expander;
                e.last  = 1'b0;
                owed.push_back(e);
            end
            // repeat frame copies the eighth
            e.cyc   = 2'd3;
            e.half  = 1'b1;
            e.latch = 1'b0;
            e.last  = 1'b1;
            owed.push_back(e);
        endfunction

        function void check_frame(t_frame_exp got);
            t_frame_exp e;
            if (owed.size() == 0) begin
                $display("%0t unexpected frame %h", $time, got.frame);
                errors++;
                return;
            end
            e = owed.pop_front();
            if (got.frame !== e.frame) begin
                $display("%0t frame exp %h got %h", $time, e.frame, got.frame);
                errors++;
            end
            if (got.cyc !== e.cyc) begin
                $display("%0t mux_cycle exp %0d got %0d", $time, e.cyc, got.cyc);
                errors++;
            end
            if (got.half !== e.half) begin
                $display("%0t mux_half exp %0d got %0d", $time, e.half, got.half);
                errors++;
            end
            if (got.latch !== e.latch) begin
                $display("%0t mux_latch exp %0d got %0d", $time, e.latch, got.latch);
                errors++;
            end
            if (got.last !== e.last) begin
                $display("%0t last exp %0d got %0d", $time, e.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        func = 1'b0;
    logic [6:0]  unit_addr = '0;
    logic [5:0]  target_pos = '0;
    logic        unit_present = 1'b0;
    logic [31:0] now_ms = '0;
    logic [7:0]  sensor_byte = '0;
    logic        cfg_we = 1'b0;
    logic        cfg_idx = 1'b0;
    logic [15:0] cfg_data = '0;
    logic        valid;
    logic [55:0] frame;
    logic [1:0]  mux_cycle;
    logic        mux_half, mux_latch, last;

    frame_board  board;
    int unsigned send_idle_pct = 0;
    int unsigned cycles = 0;
    logic [31:0] clock_ms = 32'd1000;

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    splitflap_scan_frame_builder dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_start        (start),
        .o_busy         (busy),
        .i_func         (func),
        .i_unit_addr    (unit_addr),
        .i_target_pos   (target_pos),
        .i_unit_present (unit_present),
        .i_now_ms       (now_ms),
        .i_sensor_byte  (sensor_byte),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_data     (cfg_data),
        .o_valid        (valid),
        .o_frame        (frame),
        .o_mux_cycle    (mux_cycle),
        .o_mux_half     (mux_half),
        .o_mux_latch    (mux_latch),
        .o_last         (last)
    );

    // result side: every strobe is an accepted frame
    always @(posedge clk) begin
        if (rst_n && valid)
            board.check_frame('{frame, mux_cycle, mux_half, mux_latch, last});
    end

    // watchdog
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleCap) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // one item: optional idle gap, then hold start until the block takes it
    task automatic send_item(logic f, logic [6:0] a, logic [5:0] t, logic p,
                             logic [31:0] n, logic [7:0] s);
        while ($urandom_range(99) < send_idle_pct) @(posedge clk);
        start        <= 1'b1;
        func         <= f;
        unit_addr    <= a;
        target_pos   <= t;
        unit_present <= p;
        now_ms       <= n;
        sensor_byte  <= s;
        @(posedge clk);
        while (busy) @(posedge clk);
        board.note_item(f, a, t, p, n, s);
        start <= 1'b0;
        // block is busy after the accepting edge anyway
        @(posedge clk);
    endtask

    // wait for the owed frames, then let a stray item finish
    task automatic drain();
        @(posedge clk);
        while (board.owed.size() != 0 || busy) @(posedge clk);
        repeat (DrainWait) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [15:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        board.write_reg(idx, val);
        @(posedge clk);
    endtask

    // mixed traffic: readbacks and scans in random order, some with bad addresses or absent units, time moving on
    task automatic random_items(int n);
        logic [6:0] a;
        for (int i = 0; i < n; i++) begin
            a = ($urandom_range(19) == 0) ? 7'($urandom_range(127, 72))
                                          : 7'($urandom_range(71));
            clock_ms = clock_ms + $urandom_range(3000);
            if ($urandom_range(9) == 0) clock_ms = $urandom;
            if ($urandom_range(2) == 0)
                send_item(sfsb_pkg::FuncReadback, a, 6'($urandom), 1'($urandom),
                          $urandom, 8'($urandom));
            else
                send_item(sfsb_pkg::FuncScan, a,
                          ($urandom_range(2) == 0) ? board.position[a % NUnits]
                                                   : 6'($urandom),
                          $urandom_range(7) != 0, clock_ms, 8'($urandom));
        end
    endtask

    initial begin
        board = new();
        board.clear_state();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, readback, absent units, bad addresses
        send_item(sfsb_pkg::FuncReadback, 7'd0, 6'd0, 1'b1, 32'd0, 8'hFF);
        send_item(sfsb_pkg::FuncReadback, 7'd71, 6'd0, 1'b0, 32'd0, 8'hC5);
        send_item(sfsb_pkg::FuncReadback, 7'd127, 6'd0, 1'b1, 32'd0, 8'h2A);
        send_item(sfsb_pkg::FuncScan, 7'd0, 6'd0, 1'b1, 32'd10, 8'd0);
        send_item(sfsb_pkg::FuncScan, 7'd71, 6'd5, 1'b1, 32'd20, 8'd0);
        send_item(sfsb_pkg::FuncScan, 7'd23, 6'd63, 1'b1, 32'd30, 8'd0);
        send_item(sfsb_pkg::FuncScan, 7'd24, 6'd1, 1'b1, 32'd40, 8'd0);
        send_item(sfsb_pkg::FuncScan, 7'd47, 6'd2, 1'b1, 32'd50, 8'd0);
        send_item(sfsb_pkg::FuncScan, 7'd48, 6'd3, 1'b1, 32'd60, 8'd0);
        send_item(sfsb_pkg::FuncScan, 7'd35, 6'd3, 1'b0, 32'd70, 8'd0);
        send_item(sfsb_pkg::FuncScan, 7'd72, 6'd3, 1'b1, 32'd80, 8'd0);
        send_item(sfsb_pkg::FuncScan, 7'd127, 6'd63, 1'b1, 32'hFFFF_FFFF, 8'd0);
        // reach the target and stop
        send_item(sfsb_pkg::FuncScan, 7'd0, 6'd63, 1'b1, 32'd90, 8'd0);
        // timeout with wrap of now
        send_item(sfsb_pkg::FuncScan, 7'd9, 6'd7, 1'b1, 32'hFFFF_FF00, 8'd0);
        send_item(sfsb_pkg::FuncScan, 7'd9, 6'd7, 1'b1, 32'h0000_2000, 8'd0);
        send_item(sfsb_pkg::FuncScan, 7'd17, 6'd7, 1'b1, 32'h0000_9000, 8'd0);
        drain();

        write_reg(sfsb_pkg::CfgTimeout, 16'd0);
        send_item(sfsb_pkg::FuncScan, 7'd30, 6'd9, 1'b1, 32'd100, 8'd0);
        send_item(sfsb_pkg::FuncScan, 7'd5, 6'd9, 1'b1, 32'd100, 8'd0);
        drain();
        write_reg(sfsb_pkg::CfgUseExpander, 16'hFFFE);
        write_reg(sfsb_pkg::CfgTimeout, 16'hFFFF);
        send_item(sfsb_pkg::FuncScan, 7'd60, 6'd9, 1'b1, 32'd200, 8'd0);
        send_item(sfsb_pkg::FuncScan, 7'd10, 6'd9, 1'b1, 32'd200, 8'd0);
        drain();

        // random phases under different settings and idle patterns
        send_idle_pct = 23;
        random_items(160);
        drain();
        write_reg(sfsb_pkg::CfgUseExpander, 16'd1);
        write_reg(sfsb_pkg::CfgTimeout, 16'd1500);
        send_idle_pct = 84;
        random_items(160);
        drain();
        write_reg(sfsb_pkg::CfgUseExpander, 16'd1);
        write_reg(sfsb_pkg::CfgTimeout, 16'($urandom));
        send_idle_pct = 0;
        random_items(160);
        drain();

        if (board.errors == 0 && board.owed.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0t %0d frames never came", $time, board.owed.size());
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
